// File: src/eur_pkg.sv
// Shared constants, types and register codes for the ultrasonic echo ranger.
package eur_pkg;

  // Echo counter width and the largest number of samples averaged per run.
  localparam int ECHO_COUNT_BITS = 16;
  localparam int MAX_SAMPLES     = 8;

  // Widths that follow from the two above.
  localparam int SUM_W  = ECHO_COUNT_BITS + $clog2(MAX_SAMPLES);
  localparam int DVD_W  = SUM_W + 4;               // sum * 16
  localparam int DIV_W  = 12;                      // 8-bit cm scale times 4-bit count
  localparam int REM_W  = DIV_W + 1;
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam int EFF_W  = 5;                       // holds MAX_SAMPLES up to 31
  localparam int DIST_W = 20;
  localparam int WIDE_W = (DVD_W > DIST_W) ? DVD_W : DIST_W;

  localparam logic [ECHO_COUNT_BITS-1:0] ECHO_MAX = '1;
  localparam logic [DIST_W-1:0]          DIST_MAX = '1;
  localparam logic [3:0]                 SAMPLES_DONE_MAX = 4'd15;

  // Decoupling queue between sequencer and divider back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_WIDTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_US_PER_CM     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_GAP    = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT  = 8'd3;

  localparam logic [7:0]  TRIGGER_WIDTH_RESET = 8'd20;
  localparam logic [7:0]  US_PER_CM_RESET     = 8'd58;
  localparam logic [15:0] SETTLE_GAP_RESET    = 16'd50000;
  localparam logic [3:0]  SAMPLE_COUNT_RESET  = 4'd5;

  typedef struct packed {
    logic [7:0]  trigger_width_us;
    logic [7:0]  us_per_cm;
    logic [15:0] settle_gap_us;
    logic [3:0]  sample_count;
  } cfg_t;

  // One word per tick from front to back; sum and divisor only matter on done.
  typedef struct packed {
    logic             trigger_level;
    logic             busy;
    logic             done;
    logic             timeout;
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] divisor;
  } tick_rec_t;

endpackage

// File: src/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger: config registers, sequencer, queue, divider.
//
// Each input word is one microsecond tick (start request and sampled echo
// level); each tick yields exactly one result word giving the trigger pin
// level, busy, done, the last mean distance in sixteenths of a centimetre and
// the echo timeout flag.  A start in idle runs sample_count measurements
// (zero as one, capped at MAX_SAMPLES; trigger pulse, wait for echo, count echo
// ticks, settle gap); when the run ends the mean sum*16/(us_per_cm*samples) is
// stored, saturated at 2^20-1, and done is high on that tick.  An echo count
// saturates at its maximum and sets the timeout flag.  Rate: the sequencer takes
// a tick whenever the queue is not full; the word that closes a run goes through
// a restoring divider in the back end that produces one quotient bit per cycle,
// then waits for a free result register.  A four-word queue between sequencer
// and divider lets ticks keep entering meanwhile; the input side reports full
// only once that queue fills.  A held result does not stop the sequencer until
// the queue is full.  Configuration writes are always taken (ready is tied high)
// and belong in idle; an unknown index is ignored.
module ultrasonic_echo_ranger_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            start_req,
  input  logic                            echo_level,
  output logic                            empty,
  input  logic                            pop,
  output logic                            trigger_level,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [eur_pkg::DIST_W-1:0]      distance_sixteenths,
  output logic                            echo_timeout,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [eur_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [eur_pkg::CFG_DATA_W-1:0]  cfg_data
);

  eur_pkg::cfg_t      cfg;
  eur_pkg::tick_rec_t front_rec;
  eur_pkg::tick_rec_t q_data;
  logic               accept;
  logic               q_empty;
  logic               q_rd;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Register file; each write keeps the low bits its register holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_width_us <= eur_pkg::TRIGGER_WIDTH_RESET;
      cfg.us_per_cm        <= eur_pkg::US_PER_CM_RESET;
      cfg.settle_gap_us    <= eur_pkg::SETTLE_GAP_RESET;
      cfg.sample_count     <= eur_pkg::SAMPLE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        eur_pkg::CFG_TRIGGER_WIDTH: cfg.trigger_width_us <= cfg_data[7:0];
        eur_pkg::CFG_US_PER_CM:     cfg.us_per_cm        <= cfg_data[7:0];
        eur_pkg::CFG_SETTLE_GAP:    cfg.settle_gap_us    <= cfg_data[15:0];
        eur_pkg::CFG_SAMPLE_COUNT:  cfg.sample_count     <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Front: phase sequencing per tick, one word into the queue per tick.
  eur_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .start_req  (start_req),
    .echo_level (echo_level),
    .rec        (front_rec)
  );

  eur_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (front_rec),
    .rd      (q_rd),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  // Back: division on done words, result register towards the consumer.
  eur_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_empty             (q_empty),
    .q_data              (q_data),
    .q_rd                (q_rd),
    .empty               (empty),
    .pop                 (pop),
    .trigger_level       (trigger_level),
    .busy_res            (busy_res),
    .done_res            (done_res),
    .distance_sixteenths (distance_sixteenths),
    .echo_timeout        (echo_timeout)
  );

endmodule

// File: src/eur_front.sv
// Tick sequencer: trigger, echo wait, echo count and settle phases per sample.
module eur_front (
  input  logic              clk,
  input  logic              rst,
  input  eur_pkg::cfg_t     cfg,
  input  logic              accept,
  input  logic              start_req,
  input  logic              echo_level,
  output eur_pkg::tick_rec_t rec
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_HIGH,
    PH_SETTLE
  } phase_t;

  phase_t                              phase, phase_next;
  logic [15:0]                         phase_ticks, phase_ticks_next;
  logic [15:0]                         ticks_inc;
  logic [eur_pkg::ECHO_COUNT_BITS-1:0] echo_ticks, echo_ticks_next;
  logic [eur_pkg::SUM_W-1:0]           echo_sum, echo_sum_next;
  logic [3:0]                          samples_done, samples_done_next;
  logic                                saturated_seen, saturated_seen_next;
  logic                                trig, done, end_sample;
  logic [eur_pkg::EFF_W-1:0]           eff_samples;
  logic [7:0]                          upc_eff;
  logic [3:0]                          sd_eff;

  assign ticks_inc = phase_ticks + 16'd1;

  always_comb begin
    if (cfg.sample_count == 4'd0) begin
      eff_samples = eur_pkg::EFF_W'(1);
    end else if (eur_pkg::EFF_W'(cfg.sample_count) > eur_pkg::EFF_W'(eur_pkg::MAX_SAMPLES)) begin
      eff_samples = eur_pkg::EFF_W'(eur_pkg::MAX_SAMPLES);
    end else begin
      eff_samples = eur_pkg::EFF_W'(cfg.sample_count);
    end
  end

  always_comb begin
    phase_next          = phase;
    phase_ticks_next    = phase_ticks;
    echo_ticks_next     = echo_ticks;
    echo_sum_next       = echo_sum;
    samples_done_next   = samples_done;
    saturated_seen_next = saturated_seen;
    trig                = 1'b0;
    done                = 1'b0;
    end_sample          = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next          = PH_TRIG;
          phase_ticks_next    = '0;
          echo_ticks_next     = '0;
          echo_sum_next       = '0;
          samples_done_next   = '0;
          saturated_seen_next = 1'b0;
        end
      end
      PH_TRIG: begin
        trig = 1'b1;
        if (ticks_inc >= {8'd0, cfg.trigger_width_us}) begin
          phase_next       = PH_WAIT;
          phase_ticks_next = '0;
        end else begin
          phase_ticks_next = ticks_inc;
        end
      end
      PH_WAIT: begin
        if (echo_level) begin
          echo_ticks_next = eur_pkg::ECHO_COUNT_BITS'(1);
          phase_next      = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (echo_level) begin
          if (echo_ticks == eur_pkg::ECHO_MAX) begin
            saturated_seen_next = 1'b1;
          end else begin
            echo_ticks_next = echo_ticks + eur_pkg::ECHO_COUNT_BITS'(1);
          end
        end else begin
          echo_sum_next   = echo_sum + eur_pkg::SUM_W'(echo_ticks);
          echo_ticks_next = '0;
          if (samples_done != eur_pkg::SAMPLES_DONE_MAX) begin
            samples_done_next = samples_done + 4'd1;
          end
          if (cfg.settle_gap_us == 16'd0) begin
            end_sample = 1'b1;
          end else begin
            phase_next       = PH_SETTLE;
            phase_ticks_next = '0;
          end
        end
      end
      PH_SETTLE: begin
        phase_ticks_next = ticks_inc;
        if (ticks_inc >= cfg.settle_gap_us) begin
          end_sample = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (end_sample) begin
      phase_ticks_next = '0;
      if (eur_pkg::EFF_W'(samples_done_next) >= eff_samples) begin
        done       = 1'b1;
        phase_next = PH_IDLE;
      end else begin
        phase_next = PH_TRIG;
      end
    end
  end

  // Divisor for the mean; zero scale or count stands for one.
  assign upc_eff = (cfg.us_per_cm == 8'd0) ? 8'd1 : cfg.us_per_cm;
  assign sd_eff  = (samples_done_next == 4'd0) ? 4'd1 : samples_done_next;

  always_comb begin
    rec.trigger_level = trig;
    rec.busy          = (phase_next != PH_IDLE);
    rec.done          = done;
    rec.timeout       = saturated_seen_next;
    rec.sum           = echo_sum_next;
    rec.divisor       = eur_pkg::DIV_W'(upc_eff) * eur_pkg::DIV_W'(sd_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      phase_ticks    <= '0;
      echo_ticks     <= '0;
      echo_sum       <= '0;
      samples_done   <= '0;
      saturated_seen <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      phase_ticks    <= phase_ticks_next;
      echo_ticks     <= echo_ticks_next;
      echo_sum       <= echo_sum_next;
      samples_done   <= samples_done_next;
      saturated_seen <= saturated_seen_next;
    end
  end

endmodule

// File: src/eur_queue.sv
// Small register FIFO of tick words between sequencer and back end.
module eur_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  eur_pkg::tick_rec_t  wr_data,
  input  logic                rd,
  output eur_pkg::tick_rec_t  rd_data,
  output logic                full,
  output logic                empty
);

  eur_pkg::tick_rec_t         slots [eur_pkg::QUEUE_DEPTH];
  logic [eur_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [eur_pkg::QPTR_W:0]   count;

  assign full    = (count == (eur_pkg::QPTR_W + 1)'(eur_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + eur_pkg::QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + eur_pkg::QPTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + (eur_pkg::QPTR_W + 1)'(1);
      end else if (rd && !wr) begin
        count <= count - (eur_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: src/eur_back.sv
// Back end: restoring divider for the mean distance and the result register.
module eur_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_empty,
  input  eur_pkg::tick_rec_t         q_data,
  output logic                       q_rd,
  output logic                       empty,
  input  logic                       pop,
  output logic                       trigger_level,
  output logic                       busy_res,
  output logic                       done_res,
  output logic [eur_pkg::DIST_W-1:0] distance_sixteenths,
  output logic                       echo_timeout
);

  typedef enum logic {
    B_IDLE,
    B_DIV
  } bstate_t;

  bstate_t                     state;
  logic                        out_valid;
  logic                        slot_free;
  logic                        load_plain;
  logic [eur_pkg::DIST_W-1:0]  last_distance;
  eur_pkg::tick_rec_t          held;
  logic [eur_pkg::DVD_W-1:0]   quo;
  logic [eur_pkg::REM_W-1:0]   rem;
  logic [eur_pkg::REM_W-1:0]   rem_sh;
  logic                        fits;
  logic [eur_pkg::STEP_W-1:0]  steps;
  logic [eur_pkg::WIDE_W-1:0]  quo_wide;
  logic [eur_pkg::DIST_W-1:0]  dist_sat;
  logic                        finish;

  assign slot_free  = !out_valid || pop;
  assign empty      = !out_valid;
  assign q_rd       = (state == B_IDLE) && !q_empty && slot_free;
  assign load_plain = q_rd && !q_data.done;
  assign finish     = (state == B_DIV) && (steps == '0) && slot_free;

  // One quotient bit per cycle.
  assign rem_sh = {rem[eur_pkg::REM_W-2:0], quo[eur_pkg::DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, held.divisor});

  assign quo_wide = eur_pkg::WIDE_W'(quo);
  assign dist_sat = (quo_wide > eur_pkg::WIDE_W'(eur_pkg::DIST_MAX)) ?
                    eur_pkg::DIST_MAX : eur_pkg::DIST_W'(quo_wide);

  // Result register occupancy: filled by a plain word or a finished division.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_plain || finish) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      last_distance <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (q_rd) begin
            if (q_data.done) begin
              held  <= q_data;
              quo   <= {q_data.sum, 4'd0};
              rem   <= '0;
              steps <= eur_pkg::STEP_W'(eur_pkg::DVD_W);
              state <= B_DIV;
            end else begin
              trigger_level       <= q_data.trigger_level;
              busy_res            <= q_data.busy;
              done_res            <= 1'b0;
              echo_timeout        <= q_data.timeout;
              distance_sixteenths <= last_distance;
            end
          end
        end
        B_DIV: begin
          if (steps != '0) begin
            rem   <= fits ? (rem_sh - {1'b0, held.divisor}) : rem_sh;
            quo   <= {quo[eur_pkg::DVD_W-2:0], fits};
            steps <= steps - eur_pkg::STEP_W'(1);
          end else if (finish) begin
            last_distance       <= dist_sat;
            trigger_level       <= held.trigger_level;
            busy_res            <= held.busy;
            done_res            <= 1'b1;
            echo_timeout        <= held.timeout;
            distance_sixteenths <= dist_sat;
            state               <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/ultrasonic_echo_ranger_top_tb.sv
// Self-checking testbench for the ultrasonic echo ranger: tick stimulus, predictor and checker.
module ultrasonic_echo_ranger_top_tb;
  import eur_pkg::*;

  // Run sizing.
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int DRAIN_CYCLES    = 40;         // lets the divider back end finish
  localparam int HOLD_CYCLES     = 400;        // long receiver stall, fills the queue
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int MAX_REPORTS     = 10;

  // Index that maps to no register; the block must ignore it.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'd4;

  typedef enum logic [2:0] {
    RG_IDLE, RG_TRIG, RG_WAIT, RG_HIGH, RG_SETTLE
  } rg_phase_t;

  // One input word: a microsecond tick.
  typedef struct packed {
    logic start;
    logic echo;
  } ranger_tick_t;

  // One result word, laid out as the block reports it.
  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] dist_val;
    logic              tmo;
  } tick_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  // Block ports; the inputs are at known values from time zero.
  logic                   push = 1'b0;
  logic                   full;
  logic                   start_req = 1'b0;
  logic                   echo_level = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   trigger_level;
  logic                   busy_res;
  logic                   done_res;
  logic [DIST_W-1:0]      distance_sixteenths;
  logic                   echo_timeout;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  ultrasonic_echo_ranger_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .start_req           (start_req),
    .echo_level          (echo_level),
    .empty               (empty),
    .pop                 (pop),
    .trigger_level       (trigger_level),
    .busy_res            (busy_res),
    .done_res            (done_res),
    .distance_sixteenths (distance_sixteenths),
    .echo_timeout        (echo_timeout),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: shadow registers and sequencer state, advanced once per tick.
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_tw  = TRIGGER_WIDTH_RESET;
  logic [7:0]  cfg_upc = US_PER_CM_RESET;
  logic [15:0] cfg_gap = SETTLE_GAP_RESET;
  logic [3:0]  cfg_n   = SAMPLE_COUNT_RESET;

  rg_phase_t                rg_phase = RG_IDLE;
  logic [15:0]              rg_ticks = '0;
  logic [ECHO_COUNT_BITS-1:0] rg_echo = '0;
  int unsigned              rg_sum   = 0;
  logic [3:0]               rg_taken = '0;
  logic                     rg_sat   = 1'b0;
  logic [DIST_W-1:0]        rg_last  = '0;

  // Closes one measurement; returns 1 when the whole run has finished.
  function automatic logic close_sample();
    int unsigned lim;
    int unsigned div;
    int unsigned q;
    lim = cfg_n;
    if (lim == 0) lim = 1;
    if (lim > MAX_SAMPLES) lim = MAX_SAMPLES;
    rg_ticks = '0;
    if (rg_taken >= lim) begin
      // mean over the samples actually taken
      div = ((cfg_upc == 0) ? 1 : int'(cfg_upc)) * ((rg_taken == 0) ? 1 : int'(rg_taken));
      q = (rg_sum * 16) / div;
      rg_last = (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
      rg_phase = RG_IDLE;
      return 1'b1;
    end
    rg_phase = RG_TRIG;
    return 1'b0;
  endfunction

  function automatic tick_result_t ranger_tick(input logic start, input logic echo);
    tick_result_t r;
    logic fin;
    fin = 1'b0;
    r.trig = 1'b0;
    case (rg_phase)
      RG_IDLE: begin
        if (start) begin
          rg_phase = RG_TRIG;
          rg_ticks = '0;
          rg_echo  = '0;
          rg_sum   = 0;
          rg_taken = '0;
          rg_sat   = 1'b0;
        end
      end
      RG_TRIG: begin
        r.trig = 1'b1;
        rg_ticks = rg_ticks + 1'b1;
        // a zero width still gives one trigger tick
        if (rg_ticks >= cfg_tw) begin
          rg_phase = RG_WAIT;
          rg_ticks = '0;
        end
      end
      RG_WAIT: begin
        if (echo) begin
          rg_echo  = ECHO_COUNT_BITS'(1);
          rg_phase = RG_HIGH;
        end
      end
      RG_HIGH: begin
        if (echo) begin
          if (rg_echo >= ECHO_MAX) begin
            rg_echo = ECHO_MAX;
            rg_sat  = 1'b1;
          end else begin
            rg_echo = rg_echo + 1'b1;
          end
        end else begin
          rg_sum  = rg_sum + rg_echo;
          rg_echo = '0;
          if (rg_taken < SAMPLES_DONE_MAX) rg_taken = rg_taken + 1'b1;
          if (cfg_gap == 0) begin
            fin = close_sample();
          end else begin
            rg_phase = RG_SETTLE;
            rg_ticks = '0;
          end
        end
      end
      RG_SETTLE: begin
        rg_ticks = rg_ticks + 1'b1;
        if (rg_ticks >= cfg_gap) fin = close_sample();
      end
      default: rg_phase = RG_IDLE;
    endcase
    r.busy     = (rg_phase != RG_IDLE);
    r.done     = fin;
    r.dist_val = rg_last;
    r.tmo      = rg_sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping.
  // ---------------------------------------------------------------------------
  ranger_tick_t pending_ticks[$];
  tick_result_t expected_results[$];
  int           ticks_queued  = 0;
  int           ticks_checked = 0;
  int           errors        = 0;
  bit           idle_on       = 1'b0;   // random gaps on both sides
  bit           hold_arm      = 1'b0;   // asks for the one long receiver stall

  // ---------------------------------------------------------------------------
  // Driver: offers pending ticks, draws a gap after each accepted word.
  // ---------------------------------------------------------------------------
  int           tx_gap = 0;
  ranger_tick_t tx_next;

  always @(posedge clk) begin
    if (rst) begin
      push   <= 1'b0;
      tx_gap = 0;
    end else begin
      if (push && !full) begin
        // word taken at this edge: predict its result now
        expected_results.push_back(ranger_tick(start_req, echo_level));
        tx_gap = idle_on ? $urandom_range(0, 14) : 0;
      end else if (!push && tx_gap > 0) begin
        tx_gap = tx_gap - 1;
      end
      // the slot is free unless a word is still waiting on full
      if (!push || !full) begin
        if (tx_gap == 0 && pending_ticks.size() != 0) begin
          tx_next = pending_ticks.pop_front();
          start_req  <= tx_next.start;
          echo_level <= tx_next.echo;
          push       <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver stall, counted here so the sender keeps offering meanwhile.
  // ---------------------------------------------------------------------------
  logic rx_hold   = 1'b0;
  bit   hold_used = 1'b0;
  int   hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
      rx_hold   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      if (hold_left == 0) rx_hold <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result words, compares each with the oldest prediction.
  // ---------------------------------------------------------------------------
  int           rx_wait = 0;
  tick_result_t rx_got;
  tick_result_t rx_exp;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pop && !empty) begin
        rx_got = '{trig: trigger_level, busy: busy_res, done: done_res,
                   dist_val: distance_sixteenths, tmo: echo_timeout};
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS)
            $display("unexpected result word: trig %0b busy %0b done %0b dist %0d tmo %0b",
                     rx_got.trig, rx_got.busy, rx_got.done, rx_got.dist_val, rx_got.tmo);
        end else begin
          rx_exp = expected_results.pop_front();
          ticks_checked = ticks_checked + 1;
          if (rx_got !== rx_exp) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS)
              $display({"word %0d: expected trig %0b busy %0b done %0b dist %0d tmo %0b,",
                        " got trig %0b busy %0b done %0b dist %0d tmo %0b"},
                       ticks_checked, rx_exp.trig, rx_exp.busy, rx_exp.done,
                       rx_exp.dist_val, rx_exp.tmo, rx_got.trig, rx_got.busy,
                       rx_got.done, rx_got.dist_val, rx_got.tmo);
          end
        end
        rx_wait = idle_on ? $urandom_range(0, 14) : 0;
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      pop <= (rx_wait == 0) && !rx_hold;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog.
  // ---------------------------------------------------------------------------
  int cycles = 0;

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ultrasonic_echo_ranger_top_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_tick(input logic s, input logic e);
    pending_ticks.push_back('{start: s, echo: e});
    ticks_queued = ticks_queued + 1;
  endtask

  // Waits until every queued tick has come back, then lets the divider go quiet.
  task automatic settle_out();
    while (ticks_checked < ticks_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TRIGGER_WIDTH: cfg_tw  = val[7:0];
      CFG_US_PER_CM:     cfg_upc = val[7:0];
      CFG_SETTLE_GAP:    cfg_gap = val;
      CFG_SAMPLE_COUNT:  cfg_n   = val[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Writes all four registers and one unmapped index; upper data bits carry junk that must be dropped.
  task automatic program_ranger(input logic [7:0] tw, input logic [7:0] upc,
                                input logic [15:0] gap, input logic [3:0] n);
    write_reg(CFG_TRIGGER_WIDTH, {8'($urandom), tw});
    write_reg(CFG_US_PER_CM, {8'($urandom), upc});
    write_reg(CFG_SETTLE_GAP, gap);
    write_reg(CFG_SAMPLE_COUNT, {12'($urandom), n});
    write_reg(CFG_UNMAPPED, 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int          p;
    int          base;
    int          tw_eff;
    int          n_eff;
    int          h;
    logic [7:0]  tw;
    logic [7:0]  upc;
    logic [15:0] gap;
    logic [3:0]  n;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values seen on a few idle ticks.
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b0);
    settle_out();

    // Directed: zero width, scale and count, each treated as one, and zero gap.
    program_ranger(8'd0, 8'd0, 16'd0, 4'd0);
    queue_tick(1'b1, 1'b1);   // start
    queue_tick(1'b1, 1'b1);   // single trigger tick, start while busy ignored
    queue_tick(1'b0, 1'b0);   // echo not yet risen
    queue_tick(1'b1, 1'b0);
    queue_tick(1'b0, 1'b1);   // rise counts as one
    queue_tick(1'b1, 1'b1);
    queue_tick(1'b0, 1'b1);
    queue_tick(1'b0, 1'b0);   // fall with no gap: done on this tick
    queue_tick(1'b0, 1'b1);   // idle, echo ignored
    queue_tick(1'b1, 1'b0);   // second run
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b1);   // echo already high straight after the trigger
    queue_tick(1'b0, 1'b0);
    queue_tick(1'b0, 1'b0);
    settle_out();

    // Random phases: a fresh setting each, with fixed extremes in some of them.
    for (p = 0; p < NUM_PHASES; p++) begin
      tw  = (p == 0) ? 8'd0 : (p == 1) ? 8'd255 : (p == 2) ? 8'd1 : 8'($urandom_range(0, 4));
      upc = (p == 0) ? 8'd1 : (p == 1) ? 8'd255 : (p == 5) ? 8'd0 : 8'($urandom_range(0, 255));
      gap = (p == 0) ? 16'd0 : (p == 3) ? 16'd1 : 16'($urandom_range(0, 4));
      n   = (p == 1) ? 4'd1 : (p == 3) ? 4'd8 : (p == 4) ? 4'd15 :
            (p == 5) ? 4'd0 : 4'($urandom_range(0, 15));
      program_ranger(tw, upc, gap, n);
      tw_eff = (tw == 0) ? 1 : tw;
      n_eff  = (n == 0) ? 1 : (n > MAX_SAMPLES) ? MAX_SAMPLES : n;
      // odd phases idle at random, even ones run flat out
      idle_on = p[0];
      // back pressure while the sender streams words
      if (p == 2) hold_arm = 1'b1;

      base = ticks_queued;
      while (ticks_queued - base < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: may start stray runs and break the next sequence
          repeat ($urandom_range(2, 8))
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          queue_tick(1'b1, 1'($urandom_range(0, 1)));
          repeat (n_eff) begin
            repeat (tw_eff) queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2)) queue_tick(1'($urandom_range(0, 1)), 1'b0);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 32) : $urandom_range(1, 6);
            repeat (h) queue_tick(1'($urandom_range(0, 1)), 1'b1);
            queue_tick(1'($urandom_range(0, 1)), 1'b0);
            repeat (gap) queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          end
          repeat ($urandom_range(0, 3)) queue_tick(1'b0, 1'($urandom_range(0, 1)));
        end
      end
      settle_out();
    end

    if (expected_results.size() != 0) errors = errors + 1;
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger_top_tb OK");
    end else begin
      $display("ultrasonic_echo_ranger_top_tb NOT OK");
    end
    $finish;
  end

endmodule
